// ===== sv/zsc_pkg.sv =====
// Constants, widths and types shared by the z-score pipeline.
`default_nettype none
package zsc_pkg;

  localparam int VALUE_BITS = 16;
  localparam int COUNT_BITS = 17;
  localparam int FRAC_BITS  = 16;
  localparam int Z_BITS     = FRAC_BITS + 10;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 48;

  // intermediate widths
  localparam int NV_W   = VALUE_BITS + COUNT_BITS;
  localparam int MAG_W  = (NV_W > SUM_W) ? NV_W : SUM_W;
  localparam int ALO_W  = 32 + COUNT_BITS;
  localparam int AHI_W  = SQ_W - 32 + COUNT_BITS;
  localparam int A_W    = SQ_W + COUNT_BITS;
  localparam int B_W    = 2 * SUM_W;
  localparam int D_W    = (A_W > B_W) ? A_W : B_W;
  localparam int DLO_W  = 32 + COUNT_BITS;
  localparam int DHI_W  = D_W - 32 + COUNT_BITS;
  localparam int DEN_W  = D_W + COUNT_BITS;
  localparam int NSQ_W  = 2 * MAG_W;
  localparam int MLO_W  = 32 + COUNT_BITS;
  localparam int MHI_W  = NSQ_W - 32 + COUNT_BITS;
  localparam int NUMX_W = NSQ_W + COUNT_BITS;

  // quotient bits kept; anything larger saturates
  localparam int QB     = 2 * Z_BITS + 1;
  localparam int SH     = QB - 2 * FRAC_BITS;
  localparam int TOP_W  = NUMX_W - SH;
  localparam int CMP_W  = (TOP_W > DEN_W) ? TOP_W : DEN_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int RB     = Z_BITS + 1;
  localparam int X_W    = QB;
  localparam int TW     = 2 * RB + 1;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic       spec;  // result already decided
    logic [1:0] spst;  // status of a decided result
    logic       neg;   // sign of the deviation
    logic       ovf;   // quotient beyond the kept range
  } side_t;

endpackage
`default_nettype wire

// ===== sv/zscore_from_sums_unit.sv =====
// Top level: pipelined fixed-point z-score from sample sums.
//
// Input channel in_*: element value, sample sum, sum of squares and count,
// taken when in_valid is high and in_stall low. Result channel out_*:
// out_z_score (signed, 16 fraction bits) and out_status (0 valid,
// 1 undefined, 2 saturated), taken when out_valid is high and out_stall low.
// One result per request, in order.
// Six stages of products, sums and checks, one restoring divider stage per
// quotient bit (53), one square-root stage per root bit (27) and the output
// register. Throughput is one request per cycle while nothing stalls.
// All stages advance together while the output register is empty or taken;
// when the receiver stalls a full output, the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated.
// Synchronous reset clears every valid bit; no request is in flight after it.
`default_nettype none
module zscore_from_sums_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [zsc_pkg::VALUE_BITS-1:0]    in_element_value,
  input  wire logic [zsc_pkg::SUM_W-1:0]         in_sample_sum,
  input  wire logic [zsc_pkg::SQ_W-1:0]          in_sample_sum_squares,
  input  wire logic [zsc_pkg::COUNT_BITS-1:0]    in_sample_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [zsc_pkg::Z_BITS-1:0]      out_z_score,
  output logic [1:0]                             out_status
);

  localparam int CB     = zsc_pkg::COUNT_BITS;
  localparam int NV_W   = zsc_pkg::NV_W;
  localparam int MAG_W  = zsc_pkg::MAG_W;
  localparam int ALO_W  = zsc_pkg::ALO_W;
  localparam int AHI_W  = zsc_pkg::AHI_W;
  localparam int A_W    = zsc_pkg::A_W;
  localparam int B_W    = zsc_pkg::B_W;
  localparam int D_W    = zsc_pkg::D_W;
  localparam int DLO_W  = zsc_pkg::DLO_W;
  localparam int DHI_W  = zsc_pkg::DHI_W;
  localparam int DEN_W  = zsc_pkg::DEN_W;
  localparam int NSQ_W  = zsc_pkg::NSQ_W;
  localparam int MLO_W  = zsc_pkg::MLO_W;
  localparam int MHI_W  = zsc_pkg::MHI_W;
  localparam int NUMX_W = zsc_pkg::NUMX_W;
  localparam int QB     = zsc_pkg::QB;
  localparam int SH     = zsc_pkg::SH;
  localparam int TOP_W  = zsc_pkg::TOP_W;
  localparam int CMP_W  = zsc_pkg::CMP_W;
  localparam int REM_W  = zsc_pkg::REM_W;
  localparam int RB     = zsc_pkg::RB;
  localparam int X_W    = zsc_pkg::X_W;
  localparam int TW     = zsc_pkg::TW;
  localparam int ZB     = zsc_pkg::Z_BITS;
  localparam int FB     = zsc_pkg::FRAC_BITS;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: partial products
  logic                v1_r;
  logic [CB-1:0]       n1_r;
  logic [zsc_pkg::SUM_W-1:0] s1_r;
  logic [NV_W-1:0]     nv1_r;
  logic [B_W-1:0]      bb1_r;
  logic [ALO_W-1:0]    alo1_r;
  logic [AHI_W-1:0]    ahi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r   <= in_sample_count;
      s1_r   <= in_sample_sum;
      nv1_r  <= NV_W'(in_element_value) * NV_W'(in_sample_count);
      bb1_r  <= B_W'(in_sample_sum) * B_W'(in_sample_sum);
      alo1_r <= ALO_W'(in_sample_sum_squares[31:0]) * ALO_W'(in_sample_count);
      ahi1_r <= AHI_W'(in_sample_sum_squares[zsc_pkg::SQ_W-1:32]) *
                AHI_W'(in_sample_count);
    end
  end

  // ---------------- stage 2: deviation and n*sumsq
  logic              v2_r;
  logic [CB-1:0]     n2_r;
  logic              neg2_r;
  logic [MAG_W-1:0]  nmag2_r;
  logic [A_W-1:0]    a2_r;
  logic [B_W-1:0]    b2_r;
  logic              neg2_nxt;

  assign neg2_nxt = MAG_W'(nv1_r) < MAG_W'(s1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r    <= n1_r;
      neg2_r  <= neg2_nxt;
      nmag2_r <= neg2_nxt ? (MAG_W'(s1_r) - MAG_W'(nv1_r))
                          : (MAG_W'(nv1_r) - MAG_W'(s1_r));
      a2_r    <= A_W'(alo1_r) + (A_W'(ahi1_r) << 32);
      b2_r    <= bb1_r;
    end
  end

  // ---------------- stage 3: spread, special cases, N squared
  logic                 v3_r;
  logic [CB-1:0]        nm13_r;
  logic [D_W-1:0]       d3_r;
  logic [NSQ_W-1:0]     nsq3_r;
  logic [CB-1:0]        n3_r;
  zsc_pkg::side_t       sd3_r;
  zsc_pkg::side_t       sd3_nxt;

  always_comb begin
    sd3_nxt.neg  = neg2_r;
    sd3_nxt.ovf  = 1'b0;
    sd3_nxt.spec = 1'b0;
    sd3_nxt.spst = zsc_pkg::ST_VALID;
    if (n2_r < CB'(2)) begin
      sd3_nxt.spec = 1'b1;
      sd3_nxt.spst = zsc_pkg::ST_UNDEF;
    end else if (D_W'(a2_r) <= D_W'(b2_r)) begin
      sd3_nxt.spec = 1'b1;
      sd3_nxt.spst = (nmag2_r == '0) ? zsc_pkg::ST_UNDEF : zsc_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd3_r  <= sd3_nxt;
      n3_r   <= n2_r;
      nm13_r <= n2_r - CB'(1);
      d3_r   <= D_W'(a2_r) - D_W'(b2_r);
      nsq3_r <= NSQ_W'(nmag2_r) * NSQ_W'(nmag2_r);
    end
  end

  // ---------------- stage 4: partial products of denominator and numerator
  logic              v4_r;
  logic [DLO_W-1:0]  dlo4_r;
  logic [DHI_W-1:0]  dhi4_r;
  logic [MLO_W-1:0]  mlo4_r;
  logic [MHI_W-1:0]  mhi4_r;
  zsc_pkg::side_t    sd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd4_r  <= sd3_r;
      dlo4_r <= DLO_W'(d3_r[31:0]) * DLO_W'(n3_r);
      dhi4_r <= DHI_W'(d3_r[D_W-1:32]) * DHI_W'(n3_r);
      mlo4_r <= MLO_W'(nsq3_r[31:0]) * MLO_W'(nm13_r);
      mhi4_r <= MHI_W'(nsq3_r[NSQ_W-1:32]) * MHI_W'(nm13_r);
    end
  end

  // ---------------- stage 5: sum partial products
  logic               v5_r;
  logic [DEN_W-1:0]   den5_r;
  logic [NUMX_W-1:0]  numx5_r;
  zsc_pkg::side_t     sd5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd5_r   <= sd4_r;
      den5_r  <= DEN_W'(dlo4_r) + (DEN_W'(dhi4_r) << 32);
      numx5_r <= NUMX_W'(mlo4_r) + (NUMX_W'(mhi4_r) << 32);
    end
  end

  // ---------------- stage 6 and divider: one quotient bit per stage
  logic                dv_r   [QB+1];
  logic [DEN_W-1:0]    drem_r [QB+1];
  logic [DEN_W-1:0]    dden_r [QB+1];
  logic [QB-1:0]       dl_r   [QB+1];
  logic [QB-1:0]       dq_r   [QB+1];
  zsc_pkg::side_t      dsd_r  [QB+1];
  logic [TOP_W-1:0]    top5;
  zsc_pkg::side_t      sd6_nxt;

  assign top5 = numx5_r[NUMX_W-1:SH];

  always_comb begin
    sd6_nxt     = sd5_r;
    sd6_nxt.ovf = CMP_W'(top5) >= CMP_W'(den5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsd_r[0]  <= sd6_nxt;
      drem_r[0] <= DEN_W'(top5);
      dden_r[0] <= den5_r;
      dl_r[0]   <= QB'(numx5_r[SH-1:0]) << (2 * FB);
      dq_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [REM_W-1:0] t;
    logic             ge;
    assign t  = {drem_r[k], dl_r[k][QB-1]};
    assign ge = t >= REM_W'(dden_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (adv) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dsd_r[k+1]  <= dsd_r[k];
        dden_r[k+1] <= dden_r[k];
        drem_r[k+1] <= ge ? DEN_W'(t - REM_W'(dden_r[k])) : DEN_W'(t);
        dl_r[k+1]   <= dl_r[k] << 1;
        dq_r[k+1]   <= {dq_r[k][QB-2:0], ge};
      end
    end
  end

  // ---------------- square root: one root bit per stage
  logic             sv_r  [RB];
  logic [X_W-1:0]   sx_r  [RB];
  logic [RB-1:0]    sr_r  [RB];
  zsc_pkg::side_t   ssd_r [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int BIT = RB - 1 - j;
    logic             vin;
    logic [X_W-1:0]   xin;
    logic [RB-1:0]    rin;
    zsc_pkg::side_t   sdin;
    logic [TW-1:0]    trial;
    logic             fit;

    if (j == 0) begin : g_first
      assign vin  = dv_r[QB];
      assign xin  = X_W'(dq_r[QB]);
      assign rin  = '0;
      assign sdin = dsd_r[QB];
    end else begin : g_rest
      assign vin  = sv_r[j-1];
      assign xin  = sx_r[j-1];
      assign rin  = sr_r[j-1];
      assign sdin = ssd_r[j-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (TW'(rin) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign fit   = trial <= TW'(xin);

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j] <= 1'b0;
      else if (adv) sv_r[j] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ssd_r[j] <= sdin;
        sx_r[j]  <= fit ? (xin - X_W'(trial)) : xin;
        sr_r[j]  <= fit ? (rin | (RB'(1) << BIT)) : rin;
      end
    end
  end

  // ---------------- output register: sign, saturation
  localparam logic [RB-1:0] NEG_MAG = RB'(1) << (ZB - 1);
  localparam logic [RB-1:0] POS_MAG = NEG_MAG - RB'(1);
  localparam logic [ZB-1:0] Z_POS   = {1'b0, {(ZB-1){1'b1}}};
  localparam logic [ZB-1:0] Z_NEG   = {1'b1, {(ZB-1){1'b0}}};

  logic              out_valid_r;
  logic [ZB-1:0]     out_z_r;
  logic [1:0]        out_st_r;
  logic [ZB-1:0]     z_nxt;
  logic [1:0]        st_nxt;
  logic [RB-1:0]     mag;
  zsc_pkg::side_t    sdf;

  assign mag = sr_r[RB-1];
  assign sdf = ssd_r[RB-1];

  always_comb begin
    if (sdf.spec) begin
      st_nxt = sdf.spst;
      if (sdf.spst == zsc_pkg::ST_SAT) z_nxt = sdf.neg ? Z_NEG : Z_POS;
      else z_nxt = '0;
    end else if (sdf.ovf || (sdf.neg ? (mag > NEG_MAG) : (mag > POS_MAG))) begin
      st_nxt = zsc_pkg::ST_SAT;
      z_nxt  = sdf.neg ? Z_NEG : Z_POS;
    end else begin
      st_nxt = zsc_pkg::ST_VALID;
      z_nxt  = sdf.neg ? (ZB'(0) - ZB'(mag)) : ZB'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= sv_r[RB-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_z_r  <= z_nxt;
      out_st_r <= st_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_z_score = signed'(out_z_r);
  assign out_status  = out_st_r;

  // ---------------- assertions
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == zsc_pkg::ST_VALID || out_status == zsc_pkg::ST_UNDEF ||
                   out_status == zsc_pkg::ST_SAT))
    else $error("status code out of range");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == zsc_pkg::ST_UNDEF |-> out_z_score == '0)
    else $error("undefined result is not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == zsc_pkg::ST_SAT |->
      (out_z_r == Z_POS || out_z_r == Z_NEG))
    else $error("saturated result is not a limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !dv_r[0])
    else $error("valid bits survive reset");

endmodule
`default_nettype wire

// ===== tb/sv/zscore_from_sums_unit_test.sv =====
// Self-checking testbench for the pipelined fixed-point z-score unit.
`default_nettype none
module zscore_from_sums_unit_test;

  localparam int LATENCY = 87;

  typedef struct {
    logic signed [zsc_pkg::Z_BITS-1:0] z;
    logic [1:0]                        st;
  } zscore_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [zsc_pkg::VALUE_BITS-1:0]    in_element_value;
  logic [zsc_pkg::SUM_W-1:0]         in_sample_sum;
  logic [zsc_pkg::SQ_W-1:0]          in_sample_sum_squares;
  logic [zsc_pkg::COUNT_BITS-1:0]    in_sample_count;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [zsc_pkg::Z_BITS-1:0] out_z_score;
  logic [1:0]                        out_status;

  zscore_t pending_scores[$];
  int      errors;
  int      scores_checked;
  int      n_sat;
  int      n_undef;
  int      stall_pct;

  zscore_from_sums_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_element_value(in_element_value), .in_sample_sum(in_sample_sum),
    .in_sample_sum_squares(in_sample_sum_squares), .in_sample_count(in_sample_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_z_score(out_z_score), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer square root of a wide value, clipped to Z_BITS bits.
  function automatic logic [63:0] root_of(logic [255:0] q);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [255:0] sq;
    r = '0;
    for (int b = zsc_pkg::Z_BITS - 1; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq = 256'(cand) * 256'(cand);
      if (sq <= q) r = cand;
    end
    return r;
  endfunction

  function automatic zscore_t score_of(logic [zsc_pkg::VALUE_BITS-1:0] v,
                                       logic [zsc_pkg::SUM_W-1:0] s,
                                       logic [zsc_pkg::SQ_W-1:0] sq,
                                       logic [zsc_pkg::COUNT_BITS-1:0] n);
    zscore_t      res;
    logic [63:0]  nv;
    logic [63:0]  nmag;
    logic [63:0]  mag;
    logic [63:0]  pos_lim;
    logic [63:0]  neg_lim;
    logic         neg;
    logic [255:0] a;
    logic [255:0] b;
    logic [255:0] num;
    logic [255:0] den;
    pos_lim = (64'd1 << (zsc_pkg::Z_BITS - 1)) - 1;
    neg_lim = 64'd1 << (zsc_pkg::Z_BITS - 1);
    res.z = '0;
    res.st = zsc_pkg::ST_VALID;
    if (n < 2) begin
      res.st = zsc_pkg::ST_UNDEF;
      return res;
    end
    nv = 64'(n) * 64'(v);
    neg = nv < 64'(s);
    nmag = neg ? 64'(s) - nv : nv - 64'(s);
    a = 256'(sq) * 256'(n);
    b = 256'(s) * 256'(s);
    if (a <= b) begin
      if (nmag == 0) res.st = zsc_pkg::ST_UNDEF;
      else begin
        res.st = zsc_pkg::ST_SAT;
        res.z = neg ? zsc_pkg::Z_BITS'(neg_lim) : zsc_pkg::Z_BITS'(pos_lim);
      end
      return res;
    end
    den = (a - b) * 256'(n);
    num = ((256'(nmag) * 256'(nmag)) << (2 * zsc_pkg::FRAC_BITS)) * 256'(n - 1);
    mag = root_of(num / den);
    if (neg) begin
      if (mag > neg_lim) begin
        mag = neg_lim;
        res.st = zsc_pkg::ST_SAT;
      end
      res.z = zsc_pkg::Z_BITS'(-mag);
    end else begin
      if (mag > pos_lim) begin
        mag = pos_lim;
        res.st = zsc_pkg::ST_SAT;
      end
      res.z = zsc_pkg::Z_BITS'(mag);
    end
    return res;
  endfunction

  task automatic send_request(logic [zsc_pkg::VALUE_BITS-1:0] v,
                              logic [zsc_pkg::SUM_W-1:0] s,
                              logic [zsc_pkg::SQ_W-1:0] sq,
                              logic [zsc_pkg::COUNT_BITS-1:0] n);
    in_element_value <= v;
    in_sample_sum <= s;
    in_sample_sum_squares <= sq;
    in_sample_count <= n;
    in_valid <= 1'b1;
    pending_scores.push_back(score_of(v, s, sq, n));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid.
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Build a consistent sample of n draws from 0 to vmax and score one element.
  task automatic send_sample(int n, int vmax);
    logic [63:0] s;
    logic [63:0] sq;
    logic [31:0] x;
    s = 0;
    sq = 0;
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(vmax, 0);
      s += x;
      sq += x * x;
    end
    send_request(16'($urandom_range(vmax, 0)), 32'(s), 48'(sq), 17'(n));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(16'd5, 32'd0, 48'd0, 17'd0);                  // empty sample
    send_request(16'hFFFF, 32'd7, 48'd49, 17'd1);               // single element
    send_request(16'd3, 32'd6, 48'd18, 17'd2);                  // no spread, no deviation
    send_request(16'd4, 32'd6, 48'd18, 17'd2);                  // no spread, positive
    send_request(16'd2, 32'd6, 48'd18, 17'd2);                  // no spread, negative
    send_request(16'd0, 32'hFFFF_FFFF, 48'd0, 17'd3);           // inconsistent sums
    send_request(16'd9, 32'd1, 48'hFFFF_FFFF_FFFF, 17'd2);
    send_request(16'd1, 32'd1, 48'd1, 17'h1_0000);              // count of 65536
    send_request(16'hFFFF, 32'd65535, 48'd4294836225, 17'h1_0000);
    send_request(16'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 17'h1_FFFF);
    send_request(16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 17'h1_FFFF);
    send_request(16'd10, 32'd30, 48'd500, 17'd3);
    send_request(16'd0, 32'd30, 48'd500, 17'd3);
    send_request(16'd1, 32'd1, 48'd1, 17'd2);                   // smallest spread
    send_request(16'hAAAA, 32'h5555_5555, 48'hAAAA_5555_AAAA, 17'h0_AAAA);
    send_request(16'h5555, 32'hAAAA_AAAA, 48'h5555_AAAA_5555, 17'h1_5555);
    drop_valid();
  endtask

  task automatic test_random(int count);
    int sent;
    int burst;
    bit drained;
    sent = 0;
    drained = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(20, 1);
      for (int i = 0; i < burst && sent < count; i++, sent++) begin
        case ($urandom_range(9, 0))
          0: send_request(16'($urandom), $urandom, {16'($urandom), 32'($urandom)},
                          17'($urandom));
          1: send_sample($urandom_range(3, 0), 65535);
          2: send_sample($urandom_range(4, 2), 3);
          default: send_sample($urandom_range(40, 2), $urandom_range(65535, 1));
        endcase
      end
      if ($urandom_range(3, 0) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk);
      end
      if (!drained && sent >= count / 2) begin
        wait_drained();
        drained = 1'b1;
        stall_pct = 0;
      end
    end
    drop_valid();
  endtask

  // Receiver: stall on its own pattern, check every taken result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result z_score=%0d status=%0d", out_z_score, out_status);
        errors++;
      end else begin
        if (out_z_score !== pending_scores[0].z) begin
          $error("z_score expected %0d actual %0d", pending_scores[0].z, out_z_score);
          errors++;
        end
        if (out_status !== pending_scores[0].st) begin
          $error("status expected %0d actual %0d", pending_scores[0].st, out_status);
          errors++;
        end
        if (pending_scores[0].st == zsc_pkg::ST_SAT) n_sat++;
        if (pending_scores[0].st == zsc_pkg::ST_UNDEF) n_undef++;
        scores_checked++;
        void'(pending_scores.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(199, 0) == 0) stall_pct = $urandom_range(3, 0) * 25;
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  initial begin
    #50_000_000;
    $display("zscore_from_sums_unit verification failed");
    $finish;
  end

  initial begin
    errors = 0;
    scores_checked = 0;
    n_sat = 0;
    n_undef = 0;
    stall_pct = 25;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_element_value = '0;
    in_sample_sum = '0;
    in_sample_sum_squares = '0;
    in_sample_count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(2000);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    $display("Checked %0d z-scores (%0d saturated, %0d undefined) under random stalls.",
             scores_checked, n_sat, n_undef);
    if (errors == 0) $display("zscore_from_sums_unit verification clean");
    else $display("zscore_from_sums_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
